// ----- rtl/fpmds_pkg.sv -----
package fpmds_pkg;

   localparam int TAG_SPACE = 64;

   localparam logic [7:0] OP_MUL_A  = 8'h20;
   localparam logic [7:0] OP_MUL_B  = 8'h25;
   localparam logic [7:0] OP_DIV_A  = 8'h21;
   localparam logic [7:0] OP_DIV_B  = 8'h26;
   localparam logic [7:0] OP_SQRT_A = 8'h28;
   localparam logic [7:0] OP_SQRT_B = 8'h52;

   localparam logic [5:0] MUL_LAT_RST  = 6'd5;
   localparam logic [5:0] DIV_LAT_RST  = 6'd20;
   localparam logic [5:0] SQRT_LAT_RST = 6'd25;

   localparam logic [1:0] CSR_MUL_LAT  = 2'd0;
   localparam logic [1:0] CSR_DIV_LAT  = 2'd1;
   localparam logic [1:0] CSR_SQRT_LAT = 2'd2;

   localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
   localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;

   typedef enum logic [1:0] {
      KIND_MUL  = 2'd0,
      KIND_DIV  = 2'd1,
      KIND_SQRT = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef struct packed {
      logic     start;
      kind_type kind;
   } iter_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] value;
   } iter_rsp_type;

   function automatic kind_type op_kind(input logic [7:0] op);
      kind_type k;
      unique case (op)
         OP_MUL_A, OP_MUL_B:   k = KIND_MUL;
         OP_DIV_A, OP_DIV_B:   k = KIND_DIV;
         OP_SQRT_A, OP_SQRT_B: k = KIND_SQRT;
         default:              k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic logic is_nan(input logic [63:0] v);
      return (&v[62:52]) && (|v[51:0]);
   endfunction

   function automatic logic is_inf(input logic [63:0] v);
      return (&v[62:52]) && !(|v[51:0]);
   endfunction

   function automatic logic is_zero(input logic [63:0] v);
      return !(|v[62:0]);
   endfunction

endpackage

// ----- rtl/fpmds_iter.sv -----
module fpmds_iter
   import fpmds_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  iter_req_type req,
   input  logic [63:0]  op_a,
   input  logic [63:0]  op_b,
   output iter_rsp_type rsp
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_NORM   = 7'b0000010,
      ST_ITER   = 7'b0000100,
      ST_PACK   = 7'b0001000,
      ST_DENORM = 7'b0010000,
      ST_ROUND  = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   localparam logic signed [12:0] EMIN     = -13'sd1022;
   localparam logic signed [12:0] EMAX     = 13'sd1023;
   localparam logic signed [12:0] EFLUSH   = -13'sd1080;
   localparam logic signed [12:0] BIAS     = 13'sd1023;

   state_type               st_ff, st_in;
   kind_type                kind_ff, kind_in;
   logic                    sgn_ff, sgn_in;
   logic [52:0]             ma_ff, ma_in, mb_ff, mb_in;
   logic signed [12:0]      ea_ff, ea_in, eb_ff, eb_in, er_ff, er_in;
   logic [105:0]            acc_ff, acc_in;
   logic [59:0]             rem_ff, rem_in;
   logic [111:0]            rad_ff, rad_in;
   logic [5:0]              cnt_ff, cnt_in;
   logic [55:0]             w_ff, w_in;
   logic                    stk_ff, stk_in;
   logic [63:0]             res_ff, res_in;

   logic                    spec;
   logic [63:0]             spec_val;
   logic                    sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic [106:0]            add_x, add_y;
   logic                    add_cin;
   logic [107:0]            add_sum;
   logic                    ge;
   logic [59:0]             r2;
   logic [53:0]             rnd_m;
   logic                    rnd_inc;
   logic [52:0]             rnd_mant;
   logic signed [12:0]      rnd_e, rnd_b;
   logic                    odd;

   always_comb begin
      sa     = op_a[63];
      sb     = op_b[63];
      a_nan  = is_nan(op_a);
      b_nan  = is_nan(op_b);
      a_inf  = is_inf(op_a);
      b_inf  = is_inf(op_b);
      a_zero = is_zero(op_a);
      b_zero = is_zero(op_b);
      spec     = 1'b1;
      spec_val = 64'd0;
      unique case (req.kind)
         KIND_MUL: begin
            priority if (a_nan)                            spec_val = op_a | QUIET_BIT;
            else if (b_nan)                                spec_val = op_b | QUIET_BIT;
            else if ((a_inf && b_zero) || (a_zero && b_inf)) spec_val = DEFAULT_NAN;
            else if (a_inf || b_inf)            spec_val = {sa ^ sb, 11'h7FF, 52'd0};
            else if (a_zero || b_zero)          spec_val = {sa ^ sb, 63'd0};
            else                                spec = 1'b0;
         end
         KIND_DIV: begin
            priority if (b_zero) begin
               priority if (a_nan) spec_val = op_a | QUIET_BIT;
               else if (a_zero)    spec_val = DEFAULT_NAN;
               else                spec_val = {sa ^ sb, 11'h7FF, 52'd0};
            end
            else if (a_nan)            spec_val = op_a | QUIET_BIT;
            else if (b_nan)            spec_val = op_b | QUIET_BIT;
            else if (a_inf && b_inf)   spec_val = DEFAULT_NAN;
            else if (a_inf)            spec_val = {sa ^ sb, 11'h7FF, 52'd0};
            else if (b_inf || a_zero)  spec_val = {sa ^ sb, 63'd0};
            else                       spec = 1'b0;
         end
         KIND_SQRT: begin
            priority if (b_nan) spec_val = op_b | QUIET_BIT;
            else if (b_zero)    spec_val = op_b;
            else if (sb)        spec_val = DEFAULT_NAN;
            else if (b_inf)     spec_val = op_b;
            else                spec = 1'b0;
         end
         default: spec_val = 64'd0;
      endcase
   end

   // shared add / trial subtract
   always_comb begin
      r2      = {rem_ff[57:0], rad_ff[111:110]};
      add_x   = {1'b0, acc_ff};
      add_y   = '0;
      add_cin = 1'b0;
      unique case (kind_ff)
         KIND_MUL: begin
            add_x = {acc_ff, 1'b0};
            add_y = mb_ff[52] ? {54'd0, ma_ff} : '0;
         end
         KIND_DIV: begin
            add_x   = {47'd0, rem_ff};
            add_y   = ~{54'd0, mb_ff};
            add_cin = 1'b1;
         end
         KIND_SQRT: begin
            add_x   = {47'd0, r2};
            add_y   = ~{47'd0, acc_ff[57:0], 2'b01};
            add_cin = 1'b1;
         end
         default: add_y = '0;
      endcase
      add_sum = {1'b0, add_x} + {1'b0, add_y} + {107'd0, add_cin};
      ge      = add_sum[107];
   end

   always_comb begin
      rnd_inc  = w_ff[2] && (w_ff[1] || w_ff[0] || stk_ff || w_ff[3]);
      rnd_m    = {1'b0, w_ff[55:3]} + {53'd0, rnd_inc};
      rnd_mant = rnd_m[53] ? rnd_m[53:1] : rnd_m[52:0];
      rnd_e    = er_ff + (rnd_m[53] ? 13'sd1 : 13'sd0);
      rnd_b    = rnd_e + BIAS;
      odd      = eb_ff[0];
   end

   always_comb begin
      st_in   = st_ff;
      kind_in = kind_ff;
      sgn_in  = sgn_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      ea_in   = ea_ff;
      eb_in   = eb_ff;
      er_in   = er_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      rad_in  = rad_ff;
      cnt_in  = cnt_ff;
      w_in    = w_ff;
      stk_in  = stk_ff;
      res_in  = res_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (req.start) begin
               kind_in = req.kind;
               sgn_in  = (req.kind == KIND_SQRT) ? 1'b0 : (sa ^ sb);
               ma_in   = {|op_a[62:52], op_a[51:0]};
               mb_in   = {|op_b[62:52], op_b[51:0]};
               ea_in   = (|op_a[62:52]) ? $signed({2'b00, op_a[62:52]}) - BIAS : EMIN;
               eb_in   = (|op_b[62:52]) ? $signed({2'b00, op_b[62:52]}) - BIAS : EMIN;
               if (spec) begin
                  res_in = spec_val;
                  st_in  = ST_DONE;
               end else begin
                  st_in = ST_NORM;
               end
            end
         end
         ST_NORM: begin
            if (!ma_ff[52] && kind_ff != KIND_SQRT) begin
               ma_in = {ma_ff[51:0], 1'b0};
               ea_in = ea_ff - 13'sd1;
            end
            if (!mb_ff[52]) begin
               mb_in = {mb_ff[51:0], 1'b0};
               eb_in = eb_ff - 13'sd1;
            end
            if (mb_ff[52] && (ma_ff[52] || kind_ff == KIND_SQRT)) begin
               st_in  = ST_ITER;
               acc_in = '0;
               rem_in = '0;
               unique case (kind_ff)
                  KIND_MUL:  cnt_in = 6'd53;
                  KIND_DIV: begin
                     cnt_in = 6'd57;
                     rem_in = {7'd0, ma_ff};
                  end
                  KIND_SQRT: begin
                     cnt_in = 6'd56;
                     rad_in = {(odd ? {mb_ff, 1'b0} : {1'b0, mb_ff}), 58'd0};
                     er_in  = (eb_ff - (odd ? 13'sd1 : 13'sd0)) >>> 1;
                  end
                  default: cnt_in = 6'd53;
               endcase
            end
         end
         ST_ITER: begin
            unique case (kind_ff)
               KIND_MUL: begin
                  acc_in = add_sum[105:0];
                  mb_in  = {mb_ff[51:0], 1'b0};
               end
               KIND_DIV: begin
                  rem_in = ge ? {add_sum[58:0], 1'b0} : {rem_ff[58:0], 1'b0};
                  acc_in = {acc_ff[104:0], ge};
               end
               KIND_SQRT: begin
                  rem_in = ge ? add_sum[59:0] : r2;
                  acc_in = {acc_ff[104:0], ge};
                  rad_in = {rad_ff[109:0], 2'b00};
               end
               default: acc_in = acc_ff;
            endcase
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) st_in = ST_PACK;
         end
         ST_PACK: begin
            st_in = ST_DENORM;
            unique case (kind_ff)
               KIND_MUL: begin
                  if (acc_ff[105]) begin
                     w_in   = acc_ff[105:50];
                     stk_in = |acc_ff[49:0];
                     er_in  = ea_ff + eb_ff + 13'sd1;
                  end else begin
                     w_in   = acc_ff[104:49];
                     stk_in = |acc_ff[48:0];
                     er_in  = ea_ff + eb_ff;
                  end
               end
               KIND_DIV: begin
                  if (acc_ff[56]) begin
                     w_in   = acc_ff[56:1];
                     stk_in = acc_ff[0] || (|rem_ff);
                     er_in  = ea_ff - eb_ff;
                  end else begin
                     w_in   = acc_ff[55:0];
                     stk_in = |rem_ff;
                     er_in  = ea_ff - eb_ff - 13'sd1;
                  end
               end
               KIND_SQRT: begin
                  w_in   = acc_ff[55:0];
                  stk_in = |rem_ff;
               end
               default: w_in = w_ff;
            endcase
         end
         ST_DENORM: begin
            priority if (er_ff < EFLUSH) begin
               stk_in = stk_ff || (|w_ff);
               w_in   = '0;
               er_in  = EMIN;
            end else if (er_ff < EMIN) begin
               stk_in = stk_ff || w_ff[0];
               w_in   = {1'b0, w_ff[55:1]};
               er_in  = er_ff + 13'sd1;
            end else begin
               st_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            st_in = ST_DONE;
            if (rnd_e > EMAX)
               res_in = {sgn_ff, 11'h7FF, 52'd0};
            else
               res_in = {sgn_ff, (rnd_mant[52] ? rnd_b[10:0] : 11'd0), rnd_mant[51:0]};
         end
         ST_DONE: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
      kind_ff <= kind_in;
      sgn_ff  <= sgn_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      ea_ff   <= ea_in;
      eb_ff   <= eb_in;
      er_ff   <= er_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      rad_ff  <= rad_in;
      cnt_ff  <= cnt_in;
      w_ff    <= w_in;
      stk_ff  <= stk_in;
      res_ff  <= res_in;
   end

   assign rsp.done  = (st_ff == ST_DONE);
   assign rsp.value = res_ff;

endmodule

// ----- rtl/fp_mul_div_sqrt_unit_core.sv -----
// channel  dir  handshake             payload
// req      in   req_tvalid/req_tready  req_tdata: one tick of the unit
// rsp      out  rsp_tvalid/rsp_tready  rsp_tdata: unit outputs before the tick
// csr      in   csr_we                 csr_idx, csr_wdata: latency registers
//
// A word is taken without a stall when the unit needs no arithmetic on that tick.
// A tick whose countdown hits zero on a known opcode runs the shared shift/add
// unit and holds req_tready low while it normalises subnormal inputs, iterates,
// packs, shifts tiny results down to denormal range, rounds and finishes.
// Special operands skip straight to the finish.
// A stalled rsp register also holds req_tready low. Synchronous reset.
module fp_mul_div_sqrt_unit_core
   import fpmds_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // flush, start_req, cdb_stall, mode[7:0], operand_a[63:0], operand_b[63:0],
   // dest_tag[5:0], zero pad
   input  logic [151:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // unit_free, bus_request, result_tag[5:0], result_value[63:0]
   output logic [71:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_idx,
   input  logic [5:0]   csr_wdata
);

   logic        busy_ff, busy_in, fin_ff, fin_in, wait_ff, wait_in;
   logic [5:0]  cnt_ff, cnt_in, tag_ff, tag_in;
   logic [7:0]  op_ff, op_in;
   logic [63:0] a_ff, a_in, b_ff, b_in, result_ff, result_in;
   logic [5:0]  mul_lat_ff, div_lat_ff, sqrt_lat_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [71:0] rsp_data_ff, rsp_data_in;

   logic        acc, flush, start, stall, fire;
   logic [7:0]  mode;
   logic [5:0]  dec, lat, dtag;
   kind_type    mode_kind;
   iter_req_type ireq;
   iter_rsp_type irsp;

   assign flush = req_tdata[0];
   assign start = req_tdata[1];
   assign stall = req_tdata[2];
   assign mode  = req_tdata[10:3];
   assign dtag  = req_tdata[144:139];
   assign mode_kind = op_kind(mode);
   assign dec = cnt_ff - 6'd1;

   assign req_tready = !wait_ff && (!rsp_valid_ff || rsp_tready);
   assign acc = req_tvalid && req_tready;

   always_comb begin
      unique case (mode_kind)
         KIND_DIV:  lat = div_lat_ff;
         KIND_SQRT: lat = sqrt_lat_ff;
         default:   lat = mul_lat_ff;
      endcase
   end

   always_comb begin
      logic b1, f1;
      b1           = busy_ff;
      f1           = fin_ff;
      busy_in      = busy_ff;
      fin_in       = fin_ff;
      wait_in      = wait_ff;
      cnt_in       = cnt_ff;
      tag_in       = tag_ff;
      op_in        = op_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      fire         = 1'b0;
      if (acc) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {fin_ff ? result_ff : 64'd0, fin_ff ? tag_ff : 6'd0,
                         fin_ff, !busy_ff};
         if (flush) begin
            busy_in = 1'b0;
            fin_in  = 1'b0;
         end else begin
            if (f1 && !stall) begin
               b1 = 1'b0;
               f1 = 1'b0;
            end
            if (b1 && !f1) begin
               cnt_in = dec;
               fire   = (dec == 6'd0);
            end
            if (!b1 && start) begin
               b1     = 1'b1;
               f1     = 1'b0;
               op_in  = mode;
               a_in   = req_tdata[74:11];
               b_in   = req_tdata[138:75];
               tag_in = 6'(dtag % TAG_SPACE);
               cnt_in = lat;
            end
            busy_in = b1;
            fin_in  = f1;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire) begin
         if (op_kind(op_ff) == KIND_NONE) begin
            result_in = 64'd0;
            fin_in    = 1'b1;
         end else begin
            wait_in = 1'b1;
         end
      end
      if (irsp.done) begin
         result_in = irsp.value;
         fin_in    = 1'b1;
         wait_in   = 1'b0;
      end
   end

   assign ireq.start = fire && (op_kind(op_ff) != KIND_NONE);
   assign ireq.kind  = op_kind(op_ff);

   fpmds_iter u_iter (
      .clock (clock),
      .reset (reset),
      .req   (ireq),
      .op_a  (a_ff),
      .op_b  (b_ff),
      .rsp   (irsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         fin_ff       <= 1'b0;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= 6'd0;
         tag_ff       <= 6'd0;
         op_ff        <= 8'd0;
         a_ff         <= 64'd0;
         b_ff         <= 64'd0;
         result_ff    <= 64'd0;
         mul_lat_ff   <= MUL_LAT_RST;
         div_lat_ff   <= DIV_LAT_RST;
         sqrt_lat_ff  <= SQRT_LAT_RST;
      end else begin
         busy_ff      <= busy_in;
         fin_ff       <= fin_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         tag_ff       <= tag_in;
         op_ff        <= op_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         result_ff    <= result_in;
         if (csr_we) begin
            if (csr_idx == CSR_MUL_LAT)  mul_lat_ff  <= csr_wdata;
            if (csr_idx == CSR_DIV_LAT)  div_lat_ff  <= csr_wdata;
            if (csr_idx == CSR_SQRT_LAT) sqrt_lat_ff <= csr_wdata;
         end
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_wait_blocks: assert property (@(posedge clock) disable iff (reset)
      wait_ff |-> !req_tready) else $error("word taken while computing");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      irsp.done |-> wait_ff) else $error("unexpected result from shared unit");

   a_fin_busy: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> busy_ff) else $error("finished without operation");

   a_wait_busy: assert property (@(posedge clock) disable iff (reset)
      wait_ff |-> (busy_ff && !fin_ff)) else $error("compute without pending op");

endmodule
